### rtl/anhdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package anhdl_pkg;

    // Field widths of the item formats
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BASE_W  = 15;

    // Archive layout: fixed header, then one directory record per entry
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned ENTRY_BYTES  = 12;

    // Item kinds carried in the input tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NAME = 1'b1;

    // One directory record as stored in memory
    typedef struct packed {
        logic [WORD_W-1:0] end_ofs;
        logic [WORD_W-1:0] start_ofs;
        logic [WORD_W-1:0] hash;
    } t_dir_entry;

    // One filename byte moving into the hash unit
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_name_byte;

    // One lookup result
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [WORD_W-1:0]  name_hash;
        logic [WORD_W-1:0]  data_start;
        logic [WORD_W-1:0]  data_length;
    } t_result;

endpackage

`default_nettype wire

### rtl/anhdl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module anhdl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/anhdl_name_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module anhdl_name_hash (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire anhdl_pkg::t_name_byte    i_byte,
    output logic [anhdl_pkg::WORD_W-1:0]  o_name_id
);

    logic [anhdl_pkg::WORD_W-1:0] r_id;
    logic [anhdl_pkg::WORD_W-1:0] r_word;
    logic [1:0]                   r_slot;
    logic [anhdl_pkg::WORD_W-1:0] word_next;
    logic [anhdl_pkg::WORD_W-1:0] id_next;
    logic                         word_done;

    // Place the byte into its little-endian lane
    always_comb begin
        word_next = r_word;
        case (r_slot)
            2'd0:    word_next[7:0]   = i_byte.data;
            2'd1:    word_next[15:8]  = i_byte.data;
            2'd2:    word_next[23:16] = i_byte.data;
            default: word_next[31:24] = i_byte.data;
        endcase
    end

    // Fold a finished word into the running id
    assign word_done = (r_slot == 2'd3) || i_byte.last;
    assign id_next   = {r_id[anhdl_pkg::WORD_W-2:0], r_id[anhdl_pkg::WORD_W-1]} + word_next;
    assign o_name_id = id_next;

    // Advance the packer; clear everything at the end of a name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= '0;
            r_word <= '0;
            r_slot <= '0;
        end else if (i_byte.valid) begin
            if (i_byte.last) begin
                r_id   <= '0;
                r_word <= '0;
                r_slot <= '0;
            end else if (word_done) begin
                r_id   <= id_next;
                r_word <= '0;
                r_slot <= '0;
            end else begin
                r_word <= word_next;
                r_slot <= r_slot + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/anhdl_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module anhdl_scan #(
    parameter int MAX_ENTRIES = 1024,
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [anhdl_pkg::WORD_W-1:0]  i_id,
    input  wire logic [anhdl_pkg::COUNT_W-1:0] i_count,
    output logic                               o_busy,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  wire anhdl_pkg::t_dir_entry         i_rd_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output anhdl_pkg::t_result                 o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_limit;
    logic [CW-1:0]                  r_issue;
    logic [CW-1:0]                  r_pend_idx;
    logic                           r_pend;
    logic [anhdl_pkg::WORD_W-1:0]   r_id;
    logic [anhdl_pkg::BASE_W-1:0]   r_base;
    logic                           r_found;
    logic [anhdl_pkg::INDEX_W-1:0]  r_index;
    logic [anhdl_pkg::WORD_W-1:0]   r_start;
    logic [anhdl_pkg::WORD_W-1:0]   r_end;
    logic [CW-1:0]                  limit_next;
    logic [anhdl_pkg::BASE_W-1:0]   base_next;
    logic                           more;
    logic                           hit;

    // Search covers no more slots than the memory holds
    assign limit_next = ({6'd0, i_count} < 17'(MAX_ENTRIES)) ? CW'(i_count)
                                                              : CW'(MAX_ENTRIES);
    assign base_next  = anhdl_pkg::BASE_W'(anhdl_pkg::HEADER_BYTES)
                      + anhdl_pkg::BASE_W'(anhdl_pkg::ENTRY_BYTES)
                      * anhdl_pkg::BASE_W'(i_count);

    // Issue one slot read per cycle while slots remain
    assign more      = r_issue < r_limit;
    assign o_rd_en   = (r_state == S_SCAN) && more;
    assign o_rd_addr = r_issue[AW-1:0];
    assign hit       = r_pend && (i_rd_data.hash == r_id);
    assign o_busy    = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SCAN;
                        r_limit <= limit_next;
                        r_base  <= base_next;
                        r_id    <= i_id;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_pend     <= more && !hit;
                    r_pend_idx <= r_issue;
                    if (more) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    if (hit) begin
                        // Hold the first matching slot
                        r_found <= 1'b1;
                        r_index <= anhdl_pkg::INDEX_W'(r_pend_idx);
                        r_start <= i_rd_data.start_ofs;
                        r_end   <= i_rd_data.end_ofs;
                        r_state <= S_DONE;
                    end else if (!r_pend && !more) begin
                        r_found <= 1'b0;
                        r_index <= '0;
                        r_start <= '0;
                        r_end   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Load the output register once it is free
                    if (!o_valid || i_ready) begin
                        o_valid              <= 1'b1;
                        o_result.found       <= r_found;
                        o_result.match_index <= r_index;
                        o_result.name_hash   <= r_id;
                        o_result.data_start  <= r_found
                            ? (r_start + anhdl_pkg::WORD_W'(r_base)) : '0;
                        o_result.data_length <= r_end - r_start;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/archive_name_hash_directory_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// Filename hash lookup against an archive directory. Load items (tuser 0) write
// one directory slot (hash, start, end) into a single-port-read memory; name
// items (tuser 1) carry one filename byte each, tlast on the final byte. Loads
// and non-final bytes are taken one per cycle while no search is running.
// A final byte starts a linear search of slots 0..min(entry_count,
// MAX_ENTRIES)-1 through the memory's one read port, one slot per cycle;
// input stays stalled until the result is in the output register. The
// result register lets further loads and bytes enter while the result
// waits to be taken.
// Configuration writes are taken in any cycle; write entry_count only while
// no search is running.
module archive_name_hash_directory_lookup #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [10:0]  i_cfg_data,      // entry_count
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [9:0] entry_index, [41:10] entry_hash, [73:42] entry_start,
    // [105:74] entry_end, [113:106] name_byte, [119:114] zero
    input  wire logic [119:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,    // req_type
    input  wire logic         s_axis_tlast,    // last_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [9:0] match_index, [41:10] name_hash, [73:42] data_start,
    // [105:74] data_length, [111:106] zero
    output logic [111:0]      m_axis_tdata,
    output logic              m_axis_tuser     // found
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [anhdl_pkg::COUNT_W-1:0] r_count;
    logic                          accept;
    logic                          load_acc;
    logic                          load_ok;
    logic                          name_acc;
    logic                          busy;
    logic [9:0]                    in_index;
    anhdl_pkg::t_dir_entry         wr_entry;
    anhdl_pkg::t_dir_entry         rd_entry;
    anhdl_pkg::t_name_byte         name_byte;
    anhdl_pkg::t_result            result;
    logic [anhdl_pkg::WORD_W-1:0]  name_id;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;

    // Hold the entry count register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Input handshake and item decode
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_acc      = accept && (s_axis_tuser == anhdl_pkg::REQ_LOAD);
    assign name_acc      = accept && (s_axis_tuser == anhdl_pkg::REQ_NAME);
    assign in_index      = s_axis_tdata[9:0];
    assign load_ok       = load_acc && ({7'd0, in_index} < 17'(MAX_ENTRIES));

    assign wr_entry.hash      = s_axis_tdata[41:10];
    assign wr_entry.start_ofs = s_axis_tdata[73:42];
    assign wr_entry.end_ofs   = s_axis_tdata[105:74];

    assign name_byte.valid = name_acc;
    assign name_byte.last  = s_axis_tlast;
    assign name_byte.data  = s_axis_tdata[113:106];

    anhdl_name_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (name_byte),
        .o_name_id (name_id)
    );

    anhdl_ram #(
        .WIDTH ($bits(anhdl_pkg::t_dir_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_dir (
        .i_clk     (i_clk),
        .i_wr_en   (load_ok),
        .i_wr_addr (AW'(in_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    anhdl_scan #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (name_acc && s_axis_tlast),
        .i_id      (name_id),
        .i_count   (r_count),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_entry),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    // Pack the result item
    assign m_axis_tuser = result.found;
    assign m_axis_tdata = {6'd0, result.data_length, result.data_start,
                           result.name_hash, result.match_index};

endmodule

`default_nettype wire
